>>> design/sbd_pkg.sv
// Shared constants for the segmentation block decoder: request codes, register indexes, widths.
`default_nettype none
package sbd_pkg;

  localparam int ReqW     = 2;
  localparam int AddrW    = 9;
  localparam int DataW    = 64;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int DimW     = 10;
  localparam int IbitsW   = 6;
  localparam int WordW    = 32;

  // Request codes
  localparam logic [ReqW-1:0] REQ_LOAD_TABLE = 2'd0;
  localparam logic [ReqW-1:0] REQ_LOAD_WORD  = 2'd1;
  localparam logic [ReqW-1:0] REQ_EMIT       = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_INDEX_BITS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_DIM_X = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_DIM_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OUT_DIM_X   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OUT_DIM_Y   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OUT_DIM_Z   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_WIDE_LABELS = 3'd7;

endpackage
`default_nettype wire

>>> design/segmentation_block_decoder.sv
// Top level of the dictionary-compressed label block decoder.
//
// Load transactions (table entry or packed index word) are taken one per cycle while no emit
// is decoding and are written straight into two single-port synchronous memories. An emit
// transaction decodes the next element of the block in z, y, x order and returns one result
// through the offset, bit position, word read, index and label (or error) states; the last
// loads the output register once it is free, and the input is stalled until idle again. The
// steps are the two dependent multiplies that form the element offset, the multiply by the
// index width, and the two chained registered memory reads (packed word, then label table).
// The output register lets the next transaction be accepted while a result waits. An index
// not below the table count or the table depth, or a word address beyond the packed store,
// gives a result with decode_error and last set and restarts the block at its first element.
// There is no clearing pass after reset.
`default_nettype none
module segmentation_block_decoder #(
  parameter int MAX_ELEMS   = 512,
  parameter int TABLE_DEPTH = 512,
  parameter int LABEL_WIDTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sbd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [sbd_pkg::ReqW-1:0]     req_type_i,
  input  wire logic [sbd_pkg::AddrW-1:0]    load_addr_i,
  input  wire logic [sbd_pkg::DataW-1:0]    load_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [sbd_pkg::DataW-1:0]         label_o,
  output logic                              decode_error_o,
  output logic                              last_o
);
  import sbd_pkg::*;

  localparam int WAW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [DataW-1:0] LabelMask = {DataW{1'b1}} >> (DataW - LABEL_WIDTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFS  = 3'd1;
  localparam logic [2:0] ST_BIT  = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_IDX  = 3'd4;
  localparam logic [2:0] ST_LBL  = 3'd5;
  localparam logic [2:0] ST_ERR  = 3'd6;

  // Configuration
  logic [IbitsW-1:0] ibits_q;
  logic [DimW-1:0]   tcount_q, bdx_q, bdy_q, odx_q, ody_q, odz_q;
  logic              wide_q;

  // Control
  logic [2:0]      state_q, state_d;
  logic [DimW-1:0] pos_x_q, pos_y_q, pos_z_q, pos_x_d, pos_y_d, pos_z_d;
  logic            out_valid_q, out_valid_d;

  // Datapath
  logic [20:0]      t1_q;
  logic [30:0]      off_q;
  logic [36:0]      bitpos_q;
  logic             word_err_q;
  logic [19:0]      mul_yz;
  logic [30:0]      mul_x;
  logic [36:0]      mul_bits;
  logic [IbitsW-1:0] bits_sat;
  logic [WordW-1:0] word_addr;
  logic             word_err;
  logic [WordW-1:0] idx_mask;
  logic [WordW-1:0] idx;
  logic             idx_bad;

  // Memories
  logic [WordW-1:0]       word_mem [MAX_ELEMS];
  logic [LABEL_WIDTH-1:0] table_mem [TABLE_DEPTH];
  logic [WordW-1:0]       word_rd_q;
  logic [LABEL_WIDTH-1:0] table_rd_q;
  logic                   word_we, table_we, word_re, table_re;

  // Output register
  logic [DataW-1:0] label_q, label_d;
  logic             err_q, err_d, last_q, last_d;
  logic             out_load, slot_free;

  logic             in_acc, emit_acc;
  logic [DimW-1:0]  px_inc, py_inc, pz_inc;
  logic             done;
  logic [DataW-1:0] label_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit_acc   = in_acc && (req_type_i == REQ_EMIT);
  assign word_we    = in_acc && (req_type_i == REQ_LOAD_WORD)
                      && (32'(load_addr_i) < 32'(MAX_ELEMS));
  assign table_we   = in_acc && (req_type_i == REQ_LOAD_TABLE)
                      && (32'(load_addr_i) < 32'(TABLE_DEPTH));
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Offset arithmetic, one multiply per stage
  assign mul_yz   = 20'(bdy_q) * 20'(pos_z_q);
  assign mul_x    = 31'(bdx_q) * 31'(t1_q);
  assign bits_sat = (ibits_q > IbitsW'(32)) ? IbitsW'(32) : ibits_q;
  assign mul_bits = 37'(off_q) * 37'(bits_sat);

  assign word_addr = bitpos_q[36:5];
  assign word_err  = (word_addr >= 32'(MAX_ELEMS));
  assign word_re   = (state_q == ST_RDW) && !word_err;

  assign idx_mask = (bits_sat >= IbitsW'(32)) ? {WordW{1'b1}}
                                              : ((WordW'(1) << bits_sat) - WordW'(1));
  assign idx      = (word_rd_q >> bitpos_q[4:0]) & idx_mask;
  assign idx_bad  = (idx >= WordW'(tcount_q)) || (idx >= 32'(TABLE_DEPTH));
  assign table_re = (state_q == ST_IDX) && !word_err_q && !idx_bad;

  assign label_val = (DataW'(table_rd_q) & LabelMask)
                     & (wide_q ? {DataW{1'b1}} : {{(DataW-32){1'b0}}, {32{1'b1}}});

  // Step to the next element in x, then y, then z
  always_comb begin
    px_inc = pos_x_q + DimW'(1);
    py_inc = pos_y_q + DimW'(1);
    pz_inc = pos_z_q + DimW'(1);
    done   = 1'b0;
    pos_x_d = px_inc;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (px_inc >= odx_q) begin
      pos_x_d = '0;
      pos_y_d = py_inc;
      if (py_inc >= ody_q) begin
        pos_y_d = '0;
        pos_z_d = pz_inc;
        if (pz_inc >= odz_q) begin
          pos_z_d = '0;
          done    = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    label_d  = '0;
    err_d    = 1'b0;
    last_d   = 1'b0;
    case (state_q)
      ST_IDLE: if (emit_acc) state_d = ST_OFS;
      ST_OFS:  state_d = ST_BIT;
      ST_BIT:  state_d = ST_RDW;
      ST_RDW:  state_d = ST_IDX;
      ST_IDX: begin
        if (word_err_q || idx_bad) state_d = ST_ERR;
        else state_d = ST_LBL;
      end
      ST_LBL: begin
        if (slot_free) begin
          out_load = 1'b1;
          label_d  = label_val;
          last_d   = done;
          state_d  = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_load = 1'b1;
          err_d    = 1'b1;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      ibits_q     <= '0;
      tcount_q    <= '0;
      bdx_q       <= DimW'(8);
      bdy_q       <= DimW'(8);
      odx_q       <= DimW'(8);
      ody_q       <= DimW'(8);
      odz_q       <= DimW'(8);
      wide_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        if (state_q == ST_LBL) begin
          pos_x_q <= pos_x_d;
          pos_y_q <= pos_y_d;
          pos_z_q <= pos_z_d;
        end else begin
          // restart the block after an error
          pos_x_q <= '0;
          pos_y_q <= '0;
          pos_z_q <= '0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INDEX_BITS:  ibits_q  <= cfg_data_i[IbitsW-1:0];
          CFG_TABLE_COUNT: tcount_q <= cfg_data_i;
          CFG_BLOCK_DIM_X: bdx_q    <= cfg_data_i;
          CFG_BLOCK_DIM_Y: bdy_q    <= cfg_data_i;
          CFG_OUT_DIM_X:   odx_q    <= cfg_data_i;
          CFG_OUT_DIM_Y:   ody_q    <= cfg_data_i;
          CFG_OUT_DIM_Z:   odz_q    <= cfg_data_i;
          CFG_WIDE_LABELS: wide_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_acc) t1_q <= 21'(mul_yz) + 21'(pos_y_q);
    if (state_q == ST_OFS) off_q <= mul_x + 31'(pos_x_q);
    if (state_q == ST_BIT) bitpos_q <= mul_bits;
    if (state_q == ST_RDW) word_err_q <= word_err;
    if (out_load) begin
      label_q <= label_d;
      err_q   <= err_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) word_mem[WAW'(load_addr_i)] <= load_data_i[WordW-1:0];
    if (word_re) word_rd_q <= word_mem[word_addr[WAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (table_we) table_mem[TAW'(load_addr_i)] <= load_data_i[LABEL_WIDTH-1:0];
    if (table_re) table_rd_q <= table_mem[idx[TAW-1:0]];
  end

  assign out_valid_o    = out_valid_q;
  assign label_o        = label_q;
  assign decode_error_o = err_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

>>> design/sbd_checker.sv
// Port-level checks for the segmentation block decoder, bound to the top level.
`default_nettype none
module sbd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [sbd_pkg::ReqW-1:0]     req_type_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [sbd_pkg::DataW-1:0]    label_o,
  input wire logic                         decode_error_o,
  input wire logic                         last_o
);
  import sbd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> last_o)
    else $error("error result without last");

  a_err_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> (label_o == '0))
    else $error("error result with nonzero label");

  // An emit transaction keeps the input side busy while it decodes
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_EMIT) |=> in_stall_o)
    else $error("input accepted during decode");

endmodule

bind segmentation_block_decoder sbd_checker u_sbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .req_type_i     (req_type_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .label_o        (label_o),
  .decode_error_o (decode_error_o),
  .last_o         (last_o)
);
`default_nettype wire

>>> dv/tb_segmentation_block_decoder.sv
// Testbench for the segmentation block decoder: directed and random label decoding checks.
`timescale 1ns / 100ps
module tb_segmentation_block_decoder;
  import sbd_pkg::*;

  localparam int MAX_WORDS      = 512;
  localparam int TABLE_ENTRIES  = 512;
  localparam int NUM_REGS       = 2 ** CfgIdxW;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int MAX_REPORTS    = 200;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam logic [ReqW-1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] label;
    logic             decode_error;
    logic             last;
  } label_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ReqW-1:0]     req_type_i;
  logic [AddrW-1:0]    load_addr_i;
  logic [DataW-1:0]    load_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DataW-1:0]    label_o;
  logic                decode_error_o;
  logic                last_o;

  // Mirror of the decoder: stores, position and registers
  logic [WordW-1:0] word_store  [MAX_WORDS];
  bit               word_loaded [MAX_WORDS];
  logic [DataW-1:0] table_store [TABLE_ENTRIES];
  bit               table_loaded[TABLE_ENTRIES];
  logic [DimW-1:0]   cur_x = '0, cur_y = '0, cur_z = '0;
  logic [IbitsW-1:0] reg_ibits = '0;
  logic [DimW-1:0]   reg_tcount = '0;
  logic [DimW-1:0]   reg_bdx = 10'd8, reg_bdy = 10'd8;
  logic [DimW-1:0]   reg_odx = 10'd8, reg_ody = 10'd8, reg_odz = 10'd8;
  logic              reg_wide = 1'b1;

  label_result_t expected_labels[$];
  int unsigned   sent_items = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  bit            rx_hold_req = 1'b0;

  segmentation_block_decoder #(
    .MAX_ELEMS  (MAX_WORDS),
    .TABLE_DEPTH(TABLE_ENTRIES),
    .LABEL_WIDTH(DataW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .load_addr_i   (load_addr_i),
    .load_data_i   (load_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .label_o       (label_o),
    .decode_error_o(decode_error_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned index_width();
    return (reg_ibits > WordW) ? WordW : reg_ibits;
  endfunction

  function automatic longint unsigned element_bitpos();
    longint unsigned offset;
    offset = 64'(cur_x) + 64'(reg_bdx) * (64'(cur_y) + 64'(reg_bdy) * 64'(cur_z));
    return offset * index_width();
  endfunction

  function automatic logic [WordW-1:0] element_index(input longint unsigned bitpos);
    logic [63:0] mask;
    mask = (64'd1 << index_width()) - 64'd1;
    return WordW'((64'(word_store[bitpos / WordW]) >> (bitpos % WordW)) & mask);
  endfunction

  // Update the mirror for one accepted transaction; emits queue their result.
  function automatic void apply_request(input logic [ReqW-1:0] req,
                                        input logic [AddrW-1:0] addr,
                                        input logic [DataW-1:0] data);
    longint unsigned bitpos;
    logic [WordW-1:0] idx;
    label_result_t res;
    bit done;
    case (req)
      REQ_LOAD_TABLE: begin
        table_store[addr]  = data;
        table_loaded[addr] = 1'b1;
      end
      REQ_LOAD_WORD: begin
        word_store[addr]  = data[WordW-1:0];
        word_loaded[addr] = 1'b1;
      end
      REQ_EMIT: begin
        res = '{label: '0, decode_error: 1'b1, last: 1'b1};
        bitpos = element_bitpos();
        if (bitpos / WordW < MAX_WORDS) begin
          idx = element_index(bitpos);
          if (idx < reg_tcount && idx < TABLE_ENTRIES) begin
            res.label = table_store[idx];
            if (!reg_wide) res.label[DataW-1:WordW] = '0;
            res.decode_error = 1'b0;
            // advance x fastest, then y, then z
            done = 1'b0;
            cur_x = cur_x + DimW'(1);
            if (cur_x >= reg_odx) begin
              cur_x = '0;
              cur_y = cur_y + DimW'(1);
              if (cur_y >= reg_ody) begin
                cur_y = '0;
                cur_z = cur_z + DimW'(1);
                if (cur_z >= reg_odz) begin
                  cur_z = '0;
                  done = 1'b1;
                end
              end
            end
            res.last = done;
          end
        end
        if (res.decode_error) begin
          cur_x = '0;
          cur_y = '0;
          cur_z = '0;
        end
        expected_labels = {expected_labels, res};
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DataW-1:0] random_label();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Packed word whose index fields are mostly below the table count.
  function automatic logic [WordW-1:0] packed_indexes(input logic [AddrW-1:0] addr);
    logic [63:0] w, field, v;
    int unsigned nb, pos, limit;
    w = 64'($urandom);
    nb = index_width();
    limit = (reg_tcount < TABLE_ENTRIES) ? reg_tcount : TABLE_ENTRIES;
    if (nb != 0 && limit != 0) begin
      field = (64'd1 << nb) - 64'd1;
      pos = (nb - (int'(addr) * WordW) % nb) % nb;
      while (pos < WordW) begin
        v = ($urandom_range(0, 19) == 0) ? 64'($urandom) : 64'($urandom_range(limit - 1, 0));
        w = (w & ~(field << pos)) | ((v << pos) & (field << pos));
        pos += nb;
      end
    end
    return w[WordW-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    if (tx_quiet) return 0;
    case ($urandom_range(0, 19))
      0:          return $urandom_range(8, 30);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default:    return 0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_req(input logic [ReqW-1:0] req, input logic [AddrW-1:0] addr,
                          input logic [DataW-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    load_addr_i <= addr;
    load_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(req, addr, data);
    if (req != REQ_RESERVED) sent_items++;
  endtask

  // Emit the next element, loading first whatever entry it would read unwritten.
  task automatic emit_next();
    longint unsigned bitpos;
    logic [AddrW-1:0] waddr;
    logic [WordW-1:0] idx;
    bitpos = element_bitpos();
    if (bitpos / WordW < MAX_WORDS) begin
      waddr = AddrW'(bitpos / WordW);
      if (!word_loaded[waddr])
        send_req(REQ_LOAD_WORD, waddr, {32'($urandom), packed_indexes(waddr)});
      idx = element_index(bitpos);
      if (idx < reg_tcount && idx < TABLE_ENTRIES && !table_loaded[idx])
        send_req(REQ_LOAD_TABLE, AddrW'(idx), random_label());
    end
    send_req(REQ_EMIT, AddrW'($urandom), {$urandom, $urandom});
  endtask

  // Write all registers once the block has drained.
  task automatic set_layout(input logic [CfgDataW-1:0] ibits, tcount, bdx, bdy,
                            odx, ody, odz, wide);
    logic [CfgDataW-1:0] vals [NUM_REGS];
    vals[CFG_INDEX_BITS]  = ibits;
    vals[CFG_TABLE_COUNT] = tcount;
    vals[CFG_BLOCK_DIM_X] = bdx;
    vals[CFG_BLOCK_DIM_Y] = bdy;
    vals[CFG_OUT_DIM_X]   = odx;
    vals[CFG_OUT_DIM_Y]   = ody;
    vals[CFG_OUT_DIM_Z]   = odz;
    vals[CFG_WIDE_LABELS] = wide;
    in_valid_i <= 1'b0;
    while (expected_labels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(r);
      cfg_data_i <= vals[r];
      @(posedge clk_i);
      case (CfgIdxW'(r))
        CFG_INDEX_BITS:  reg_ibits  = vals[r][IbitsW-1:0];
        CFG_TABLE_COUNT: reg_tcount = vals[r];
        CFG_BLOCK_DIM_X: reg_bdx    = vals[r];
        CFG_BLOCK_DIM_Y: reg_bdy    = vals[r];
        CFG_OUT_DIM_X:   reg_odx    = vals[r];
        CFG_OUT_DIM_Y:   reg_ody    = vals[r];
        CFG_OUT_DIM_Z:   reg_odz    = vals[r];
        CFG_WIDE_LABELS: reg_wide   = vals[r][0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_req(REQ_RESERVED, '1, '1);
    // empty table after reset: the first element is an error
    emit_next();
  endtask

  task automatic test_index_widths();
    set_layout(10'd32, 10'd512, 10'd2, 10'd1, 10'd2, 10'd1, 10'd1, 10'd1);
    send_req(REQ_LOAD_TABLE, '1, '1);
    send_req(REQ_LOAD_WORD, '0, {32'hFFFF_FFFF, 32'd511});
    emit_next();
    emit_next();
    // width above 32 saturates; narrow labels drop the upper half
    set_layout(10'd63, 10'd512, 10'd2, 10'd1, 10'd2, 10'd1, 10'd1, 10'd0);
    emit_next();
    // three-bit fields: the second element straddles the word boundary
    set_layout(10'd3, 10'd8, 10'd10, 10'd1, 10'd1, 10'd2, 10'd1, 10'd1);
    emit_next();
    emit_next();
    set_layout(10'd0, 10'd1, 10'd8, 10'd8, 10'd8, 10'd8, 10'd8, 10'd1);
    emit_next();
  endtask

  task automatic test_table_limits();
    // index below the count but past the table
    set_layout(10'd32, 10'd1023, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    send_req(REQ_LOAD_WORD, '0, 64'd600);
    emit_next();
    // index equal to the count
    set_layout(10'd32, 10'd5, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    send_req(REQ_LOAD_WORD, '0, 64'd5);
    emit_next();
  endtask

  task automatic test_store_limit();
    // third element lands beyond the packed store
    set_layout(10'd32, 10'd512, 10'd1023, 10'd1, 10'd2, 10'd2, 10'd1, 10'd1);
    repeat (3) emit_next();
  endtask

  task automatic test_extents();
    set_layout(10'd1, 10'd2, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1);
    repeat (2) emit_next();
    set_layout(10'd0, 10'd1, 10'd8, 10'd8, 10'd8, 10'd8, 10'd8, 10'd1);
    repeat (3) emit_next();
    // shrink x below the current position: wrap at the next emit
    set_layout(10'd0, 10'd1, 10'd8, 10'd8, 10'd2, 10'd8, 10'd8, 10'd1);
    emit_next();
  endtask

  task automatic test_backpressure();
    set_layout(10'd2, 10'd4, 10'd4, 10'd4, 10'd4, 10'd4, 10'd2, 10'd1);
    tx_quiet    = 1'b1;
    rx_hold_req = 1'b1;
    repeat (40) emit_next();
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned start, steps, k, pick;
    logic [CfgDataW-1:0] ibits, tcount, bdx, bdy, odx, ody, odz, wide;
    logic [AddrW-1:0] addr;
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k == 0) ibits = 10'($urandom_range(0, 1023));
      else if (k == 1) ibits = 10'd0;
      else ibits = 10'(1 << $urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0:       tcount = 10'($urandom_range(0, 1));
        1:       tcount = 10'd512;
        2:       tcount = 10'($urandom_range(513, 1023));
        default: tcount = 10'($urandom_range(1, 64));
      endcase
      bdx = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, 8));
      bdy = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, 8));
      odx = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, 6));
      ody = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, 6));
      odz = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, 6));
      wide = 10'($urandom_range(0, 1));
      set_layout(ibits, tcount, bdx, bdy, odx, ody, odz, wide);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      steps = $urandom_range(15, 100);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        addr = AddrW'($urandom);
        if (pick < 78) emit_next();
        else if (pick < 88) send_req(REQ_LOAD_TABLE, addr, random_label());
        else if (pick < 96) send_req(REQ_LOAD_WORD, addr, {32'($urandom), packed_indexes(addr)});
        else send_req(REQ_RESERVED, addr, {$urandom, $urandom});
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Receiver: random stall runs, plus one long hold-off on request
  initial begin : rx_stall_gen
    int unsigned run;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        run = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        out_stall_i <= !rx_quiet && ($urandom_range(0, 2) == 0);
        repeat (run - 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_labels
    label_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none actual label %h error %b last %b",
                   $time, label_o, decode_error_o, last_o);
      end else begin
        want = expected_labels.pop_front();
        compare_field("label", want.label, label_o);
        compare_field("decode_error", 64'(want.decode_error), 64'(decode_error_o));
        compare_field("last", 64'(want.last), 64'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_LOAD_TABLE;
    load_addr_i <= '0;
    load_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_index_widths();
    test_table_limits();
    test_store_limit();
    test_extents();
    test_backpressure();
    test_random_phases();

    in_valid_i <= 1'b0;
    while (expected_labels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
design/sbd_pkg.sv
design/segmentation_block_decoder.sv
design/sbd_checker.sv
dv/tb_segmentation_block_decoder.sv
